// ===== sv/qgb_pkg.sv =====
package qgb_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int CW = 36;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Z    = 3'd1,
    CFG_HALF_WIDTH  = 3'd2,
    CFG_HALF_HEIGHT = 3'd3,
    CFG_TREE_LEVELS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic cnt_rd;
    logic cnt_wr;
    logic slot_rd;
    logic slot_wr;
    logic clear;
  } store_ctl_t;

endpackage

// ===== sv/qgb_split.sv =====
module qgb_split import qgb_pkg::*; #(
  parameter int MAX_LEVELS = 4,
  localparam int NN = 1 << MAX_LEVELS
) (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic signed [31:0] center,
  input  logic        [30:0] half,
  input  logic signed [31:0] pos,
  output logic      [NN-1:0] hit
);

  logic signed [CW-1:0] ctr [NN];
  logic signed [CW-1:0] nc [NN];
  logic        [NN-1:0] nhit;
  logic        [30:0]   h;
  logic        [30:0]   h2;
  logic signed [CW-1:0] h2s;
  logic signed [CW-1:0] ps;

  assign h2  = {1'b0, h[30:1]};
  assign h2s = signed'(CW'(h2));
  assign ps  = CW'(pos);

  // one lane per node; node i at a level has parent i/2 and side i%2
  for (genvar i = 0; i < NN; i++) begin : g_lane
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    assign nc[i]   = ctr[i / 2] + ((i % 2 == 1) ? h2s : -h2s);
    assign lo      = nc[i] - h2s;
    assign hi      = nc[i] + h2s;
    assign nhit[i] = hit[i / 2] && (ps >= lo) && (ps <= hi);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NN; i++) ctr[i] <= CW'(center);
      hit <= '1;
      h   <= half;
    end else if (step) begin
      for (int i = 0; i < NN; i++) ctr[i] <= nc[i];
      hit <= nhit;
      h   <= h2;
    end
  end

endmodule

// ===== sv/qgb_store.sv =====
module qgb_store import qgb_pkg::*; #(
  parameter int MAX_LEVELS = 4,
  parameter int LEAF_SLOTS = 8,
  parameter int ID_BITS    = 16,
  localparam int NL   = 1 << (2 * MAX_LEVELS),
  localparam int LAW  = (2 * MAX_LEVELS > 0) ? 2 * MAX_LEVELS : 1,
  localparam int SN   = NL * LEAF_SLOTS,
  localparam int SAW  = (SN > 1) ? $clog2(SN) : 1,
  localparam int SIW  = (LEAF_SLOTS > 1) ? $clog2(LEAF_SLOTS) : 1,
  localparam int CNTW = $clog2(LEAF_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  store_ctl_t         ctl,
  input  logic [LAW-1:0]     leaf,
  input  logic [SIW-1:0]     slot_idx,
  input  logic [CNTW-1:0]    cnt_wdata,
  input  logic [ID_BITS-1:0] slot_wdata,
  output logic [CNTW-1:0]    cnt,
  output logic [ID_BITS-1:0] slot_rdata
);

  logic [CNTW-1:0]    cnt_mem [NL];
  logic [NL-1:0]      cval;
  logic [CNTW-1:0]    cq;
  logic               cv;
  logic [ID_BITS-1:0] slot_mem [SN];
  logic [SAW-1:0]     saddr;

  assign saddr = SAW'(leaf) * SAW'(LEAF_SLOTS) + SAW'(slot_idx);
  assign cnt   = cv ? cq : '0;

  always_ff @(posedge clk) begin
    if (ctl.cnt_wr) cnt_mem[leaf] <= cnt_wdata;
    if (ctl.cnt_rd) cq <= cnt_mem[leaf];
    if (ctl.slot_wr) slot_mem[saddr] <= slot_wdata;
    if (ctl.slot_rd) slot_rdata <= slot_mem[saddr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cval <= '0;
      cv   <= 1'b0;
    end else begin
      if (ctl.cnt_wr) cval[leaf] <= 1'b1;
      if (ctl.cnt_rd) cv <= cval[leaf];
    end
  end

endmodule

// ===== sv/quadtree_grid_binning.sv =====
// Fixed-depth quadtree binning over a rectangle in Q15.16.
// Channels: input items (command, pos_x, pos_z, object_id) on in_valid/in_ready;
// results (found_id, id_valid, overflow, last) on out_valid/out_ready;
// register writes (cfg_index, cfg_data) on cfg_valid/cfg_ready, always ready.
// Insert, clear and other commands give one result; a query gives one result
// per id found (at most 32) with last on the final one, or one empty result.
// One item at a time. Insert/query: level splitting (all nodes of a level in
// parallel lanes), then a scan of all 4^L leaves, with a count read for each
// matching leaf and, for a query, slot reads of its ids, then the final result
// is handed off. Clear: the leaf counts carry valid bits cleared at once.
// Reset restores the register defaults and empties every leaf.
// A stalled receiver holds the output register; a query below the result cap
// then pauses its slot reads until the pending result is taken.
module quadtree_grid_binning import qgb_pkg::*; #(
  parameter int MAX_LEVELS = 4,
  parameter int LEAF_SLOTS = 8,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_z,
  input  logic [15:0] object_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] found_id,
  output logic        id_valid,
  output logic        overflow,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NN   = 1 << MAX_LEVELS;
  localparam int LAW  = (2 * MAX_LEVELS > 0) ? 2 * MAX_LEVELS : 1;
  localparam int PW   = (MAX_LEVELS > 0) ? MAX_LEVELS : 1;
  localparam int SIW  = (LEAF_SLOTS > 1) ? $clog2(LEAF_SLOTS) : 1;
  localparam int CNTW = $clog2(LEAF_SLOTS + 1);
  localparam int NFW  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LEVEL = 6'b000010,
    S_SCAN  = 6'b000100,
    S_CNT   = 6'b001000,
    S_SLOT  = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t              state;
  logic signed [31:0]  center_x;
  logic signed [31:0]  center_z;
  logic [30:0]         half_width;
  logic [30:0]         half_height;
  logic [2:0]          tree_levels;
  logic [2:0]          depth;
  logic [2:0]          depth_next;
  logic [2:0]          lvl;
  cmd_t                cmd;
  logic signed [31:0]  px;
  logic signed [31:0]  pz;
  logic [ID_BITS-1:0]  id;
  logic [LAW-1:0]      leaf;
  logic [LAW-1:0]      last_leaf;
  logic                over;
  logic                hasheld;
  logic [ID_BITS-1:0]  held;
  logic [NFW-1:0]      nfound;
  logic [CNTW-1:0]     qcnt;
  logic [SIW-1:0]      sidx;
  logic                ovalid;
  logic [ID_BITS-1:0]  oid;
  logic                oidv;
  logic                oover;
  logic                olast;
  logic                ofree;
  logic                emit;
  logic [PW-1:0]       xp;
  logic [PW-1:0]       zp;
  logic [NN-1:0]       hx;
  logic [NN-1:0]       hz;
  logic                leaf_hit;
  logic                accept;
  logic                start;
  logic                step;
  logic                consume;
  logic                more;
  logic [31:0]         id_wide;
  logic [31:0]         oid_wide;
  store_ctl_t          ctl;
  logic [SIW-1:0]      slot_idx;
  logic [CNTW-1:0]     cnt;
  logic [ID_BITS-1:0]  slot_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ofree     = !ovalid || out_ready;

  assign out_valid = ovalid;
  assign oid_wide  = 32'(oid);
  assign found_id  = oid_wide[15:0];
  assign id_valid  = oidv;
  assign overflow  = oover;
  assign last      = olast;
  assign id_wide   = {16'd0, object_id};

  assign depth_next = (tree_levels > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : tree_levels;
  assign last_leaf  = LAW'((32'd1 << (2 * depth)) - 32'd1);

  always_comb begin
    xp = '0;
    zp = '0;
    for (int t = 0; t < MAX_LEVELS; t++) begin
      xp[t] = leaf[2 * t] ^ leaf[2 * t + 1];
      zp[t] = leaf[2 * t + 1];
    end
  end
  assign leaf_hit = hx[xp] && hz[zp];

  assign start   = accept && (command == CMD_INSERT || command == CMD_QUERY);
  assign step    = (state == S_LEVEL);
  assign consume = (nfound >= NFW'(MAX_RESULTS)) || !hasheld || ofree;
  assign more    = (CNTW'(sidx) + CNTW'(1)) < qcnt;
  assign emit    = (state == S_SLOT && consume && nfound < NFW'(MAX_RESULTS) && hasheld) ||
                   (state == S_FINAL && ofree);

  always_comb begin
    ctl      = '0;
    slot_idx = '0;
    case (state)
      S_IDLE: ctl.clear = accept && (command == CMD_CLEAR);
      S_SCAN: ctl.cnt_rd = leaf_hit;
      S_CNT: begin
        if (cmd == CMD_INSERT) begin
          ctl.cnt_wr  = cnt < CNTW'(LEAF_SLOTS);
          ctl.slot_wr = cnt < CNTW'(LEAF_SLOTS);
          slot_idx    = cnt[SIW-1:0];
        end else begin
          ctl.slot_rd = cnt != '0;
        end
      end
      S_SLOT: begin
        ctl.slot_rd = consume && more;
        slot_idx    = sidx + SIW'(1);
      end
      default: ;
    endcase
  end

  qgb_split #(.MAX_LEVELS(MAX_LEVELS)) u_split_x (
    .clk(clk), .start(start), .step(step), .center(center_x),
    .half(half_width), .pos(px), .hit(hx)
  );

  qgb_split #(.MAX_LEVELS(MAX_LEVELS)) u_split_z (
    .clk(clk), .start(start), .step(step), .center(center_z),
    .half(half_height), .pos(pz), .hit(hz)
  );

  qgb_store #(.MAX_LEVELS(MAX_LEVELS), .LEAF_SLOTS(LEAF_SLOTS), .ID_BITS(ID_BITS)) u_store (
    .clk(clk), .rst(rst), .ctl(ctl), .leaf(leaf), .slot_idx(slot_idx),
    .cnt_wdata(cnt + CNTW'(1)), .slot_wdata(id), .cnt(cnt), .slot_rdata(slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_z    <= '0;
      half_width  <= 31'd65536;
      half_height <= 31'd65536;
      tree_levels <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X:    center_x    <= cfg_data;
        CFG_CENTER_Z:    center_z    <= cfg_data;
        CFG_HALF_WIDTH:  half_width  <= cfg_data[30:0];
        CFG_HALF_HEIGHT: half_height <= cfg_data[30:0];
        CFG_TREE_LEVELS: tree_levels <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ovalid  <= 1'b0;
      hasheld <= 1'b0;
      over    <= 1'b0;
      nfound  <= '0;
      cmd     <= CMD_INSERT;
    end else begin
      ovalid <= emit || (ovalid && !out_ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd     <= cmd_t'(command);
            px      <= pos_x;
            pz      <= pos_z;
            id      <= id_wide[ID_BITS-1:0];
            depth   <= depth_next;
            lvl     <= '0;
            leaf    <= '0;
            over    <= 1'b0;
            hasheld <= 1'b0;
            nfound  <= '0;
            if (start) begin
              state <= (depth_next == '0) ? S_SCAN : S_LEVEL;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_LEVEL: begin
          lvl <= lvl + 3'd1;
          if (lvl + 3'd1 == depth) state <= S_SCAN;
        end
        S_SCAN: begin
          if (leaf_hit) begin
            state <= S_CNT;
          end else if (leaf == last_leaf) begin
            state <= S_FINAL;
          end else begin
            leaf <= leaf + LAW'(1);
          end
        end
        S_CNT: begin
          if (cmd == CMD_INSERT && cnt >= CNTW'(LEAF_SLOTS)) over <= 1'b1;
          qcnt <= cnt;
          sidx <= '0;
          if (cmd == CMD_QUERY && cnt != '0) begin
            state <= S_SLOT;
          end else if (leaf == last_leaf) begin
            state <= S_FINAL;
          end else begin
            leaf  <= leaf + LAW'(1);
            state <= S_SCAN;
          end
        end
        S_SLOT: begin
          if (consume) begin
            if (nfound < NFW'(MAX_RESULTS)) begin
              if (hasheld) begin
                oid    <= held;
                oidv   <= 1'b1;
                oover  <= 1'b0;
                olast  <= 1'b0;
              end
              held    <= slot_rdata;
              hasheld <= 1'b1;
              nfound  <= nfound + NFW'(1);
            end
            sidx <= sidx + SIW'(1);
            if (!more) begin
              if (leaf == last_leaf) begin
                state <= S_FINAL;
              end else begin
                leaf  <= leaf + LAW'(1);
                state <= S_SCAN;
              end
            end
          end
        end
        S_FINAL: begin
          if (ofree) begin
            oid    <= hasheld ? held : '0;
            oidv   <= hasheld;
            oover  <= hasheld ? 1'b0 : over;
            olast  <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_nfound_cap: assert property (@(posedge clk) disable iff (rst)
    nfound <= NFW'(MAX_RESULTS))
    else $error("result count beyond cap");
  a_held_query: assert property (@(posedge clk) disable iff (rst)
    hasheld |-> cmd == CMD_QUERY)
    else $error("held id outside a query");
  a_out_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(overflow && id_valid))
    else $error("id and overflow together");
  a_idle_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && ofree) |=> in_ready && out_valid && last)
    else $error("final result not issued");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench import qgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS_MAX = 4;
  localparam int SLOTS = 8;
  localparam int NLEAF = 256;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [15:0] id;
    logic        vld;
    logic        ovf;
    logic        lst;
  } bin_result_t;

  typedef struct {
    cmd_t        op;
    logic [31:0] px;
    logic [31:0] pz;
    logic [15:0] oid;
    logic        typed;
    bin_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_z = '0;
  logic [15:0] object_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] found_id;
  logic        id_valid;
  logic        overflow;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  quadtree_grid_binning dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint      tree_cx, tree_cz, tree_hw, tree_hh;
  int unsigned tree_depth;
  logic [15:0] bin_ids [NLEAF][SLOTS];
  int unsigned bin_fill [NLEAF];
  bit          walk_ins;
  logic [15:0] walk_oid;
  bit          walk_ovf;
  logic [15:0] hits [$];

  bin_result_t pending_results [$];
  int          errors = 0;
  longint      cycles = 0;
  bit          long_hold = 0;
  bit          stim_done = 0;
  int          rx_wait = 0;

  task automatic report(string what, bin_result_t got, bin_result_t exp_r);
    errors++;
    $display("mismatch %s: got id=%h v=%b o=%b l=%b want id=%h v=%b o=%b l=%b",
             what, got.id, got.vld, got.ovf, got.lst,
             exp_r.id, exp_r.vld, exp_r.ovf, exp_r.lst);
  endtask

  function automatic void visit_leaf(int unsigned leaf);
    leaf = leaf % NLEAF;
    if (walk_ins) begin
      if (bin_fill[leaf] < SLOTS) begin
        bin_ids[leaf][bin_fill[leaf]] = walk_oid;
        bin_fill[leaf]++;
      end else walk_ovf = 1;
    end else begin
      for (int i = 0; i < bin_fill[leaf]; i++)
        if (hits.size() < MAX_RESULTS) hits.insert(hits.size(), bin_ids[leaf][i]);
    end
  endfunction

  function automatic void descend(longint cx, longint cz, longint hw, longint hh,
                                  int unsigned lvl, int unsigned leaf,
                                  longint px, longint pz);
    longint h2, g2, ncx, ncz;
    if (lvl == 0) begin
      visit_leaf(leaf);
      return;
    end
    h2 = hw >>> 1;
    g2 = hh >>> 1;
    for (int q = 0; q < 4; q++) begin
      ncx = cx + ((q == 1 || q == 2) ? h2 : -h2);
      ncz = cz + ((q >= 2) ? g2 : -g2);
      if (px >= ncx - h2 && px <= ncx + h2 && pz >= ncz - g2 && pz <= ncz + g2)
        descend(ncx, ncz, h2, g2, lvl - 1, leaf * 4 + q, px, pz);
    end
  endfunction

  function automatic void predict_bins(logic [1:0] op, logic [31:0] px, logic [31:0] pz,
                                       logic [15:0] oid);
    int unsigned d;
    bin_result_t r;
    d = tree_depth > LEVELS_MAX ? LEVELS_MAX : tree_depth;
    r = '{id: '0, vld: 1'b0, ovf: 1'b0, lst: 1'b1};
    if (op == CMD_INSERT) begin
      walk_ins = 1; walk_oid = oid; walk_ovf = 0;
      descend(tree_cx, tree_cz, tree_hw, tree_hh, d, 0,
              longint'($signed(px)), longint'($signed(pz)));
      r.ovf = walk_ovf;
      pending_results.insert(pending_results.size(), r);
    end else if (op == CMD_QUERY) begin
      walk_ins = 0; hits.delete();
      descend(tree_cx, tree_cz, tree_hw, tree_hh, d, 0,
              longint'($signed(px)), longint'($signed(pz)));
      if (hits.size() == 0) pending_results.insert(pending_results.size(), r);
      foreach (hits[k])
        pending_results.insert(pending_results.size(),
                               '{id: hits[k], vld: 1'b1, ovf: 1'b0,
                                 lst: k == hits.size() - 1});
    end else begin
      if (op == CMD_CLEAR) foreach (bin_fill[i]) bin_fill[i] = 0;
      pending_results.insert(pending_results.size(), r);
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X:    tree_cx = longint'($signed(val));
      CFG_CENTER_Z:    tree_cz = longint'($signed(val));
      CFG_HALF_WIDTH:  tree_hw = longint'(val[30:0]);
      CFG_HALF_HEIGHT: tree_hh = longint'(val[30:0]);
      default:         tree_depth = int'(val[2:0]);
    endcase
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1400) @(posedge clk);
  endtask

  task automatic send_item(cmd_t op, logic [31:0] px, logic [31:0] pz, logic [15:0] oid,
                           bit gaps);
    int gap;
    gap = gaps ? int'($urandom_range(0, 17)) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    pos_x     <= px;
    pos_z     <= pz;
    object_id <= oid;
    do @(posedge clk); while (!in_ready);
    predict_bins(op, px, pz, oid);
  endtask

  function automatic logic [31:0] pick_coord(longint c, longint h);
    longint v;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom));
      1: v = c - h + (h >>> 1) * $urandom_range(0, 4);
      default: v = c - h + longint'($urandom_range(0, 65535)) * (2 * h + 1) / 65536;
    endcase
    return v[31:0];
  endfunction

  // receiver
  always @(posedge clk) begin
    bin_result_t got;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{id: found_id, vld: id_valid, ovf: overflow, lst: last};
        if (pending_results.size() == 0) report("unexpected", got, got);
        else if (got !== pending_results[0]) report("field", got, pending_results.pop_front());
        else void'(pending_results.pop_front());
        rx_wait = stim_done ? 0 : int'($urandom_range(0, 17));
      end
      if (long_hold) out_ready <= 1'b0;
      else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  stim_row_t table_rows [$];

  initial begin
    logic [1:0] op;
    tree_cx = 0; tree_cz = 0; tree_hw = 65536; tree_hh = 65536; tree_depth = 4;
    foreach (bin_fill[i]) bin_fill[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    table_rows = '{
      '{CMD_QUERY, 32'h0, 32'h0, 16'h0, 1, '{16'h0, 1'b0, 1'b0, 1'b1}},
      '{CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1, '{16'h0, 1'b0, 1'b0, 1'b1}},
      '{CMD_INSERT, 32'h0, 32'h0, 16'hffff, 0, '0},
      '{CMD_INSERT, 32'h0001_0000, 32'hffff_0000, 16'h0000, 0, '0},
      '{CMD_INSERT, 32'h0000_8000, 32'h0, 16'h5a5a, 0, '0},
      '{CMD_QUERY, 32'h0, 32'h0, 16'h0, 0, '0},
      '{CMD_QUERY, 32'h0000_8000, 32'h0, 16'h0, 0, '0},
      '{CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 16'h0, 1, '{16'h0, 1'b0, 1'b0, 1'b1}},
      '{CMD_CLEAR, 32'h0, 32'h0, 16'h0, 1, '{16'h0, 1'b0, 1'b0, 1'b1}},
      '{CMD_QUERY, 32'h0, 32'h0, 16'h0, 1, '{16'h0, 1'b0, 1'b0, 1'b1}},
      '{CMD_UNKNOWN, 32'h1234, 32'h5678, 16'h9abc, 1, '{16'h0, 1'b0, 1'b0, 1'b1}}
    };
    foreach (table_rows[i]) begin
      send_item(table_rows[i].op, table_rows[i].px, table_rows[i].pz, table_rows[i].oid, 1);
      if (table_rows[i].typed && pending_results[$] !== table_rows[i].want)
        report("table", pending_results[$], table_rows[i].want);
    end
    // fill the leaves at one shared corner to overflow, then a long query on that corner
    for (int i = 0; i < 10; i++)
      send_item(CMD_INSERT, 32'h0000_4000, 32'h0000_4000, 16'(i), 0);
    send_item(CMD_QUERY, 32'h0000_4000, 32'h0000_4000, 16'h0, 0);
    drain_out();

    // depth zero: everything in the root, inserts long past the slot limit, then a query
    write_reg(CFG_TREE_LEVELS, 32'd0);
    for (int i = 0; i < 36; i++) send_item(CMD_INSERT, $urandom, $urandom, 16'($urandom), 0);
    send_item(CMD_QUERY, $urandom, $urandom, 16'h0, 0);
    send_item(CMD_CLEAR, 32'h0, 32'h0, 16'h0, 0);
    drain_out();

    // random phases over several geometries
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CENTER_X, ph == 1 ? 32'h7fff_ffff : ph == 2 ? 32'h8000_0000 : $urandom);
      write_reg(CFG_CENTER_Z, ph == 1 ? 32'h8000_0000 : ph == 2 ? 32'h7fff_ffff : $urandom);
      write_reg(CFG_HALF_WIDTH, ph == 1 ? 32'hffff_ffff : ph == 3 ? 32'h0 :
                $urandom_range(1, 32'h00ff_ffff));
      write_reg(CFG_HALF_HEIGHT, ph == 1 ? 32'h7fff_ffff : ph == 3 ? 32'h0 :
                $urandom_range(1, 32'h00ff_ffff));
      write_reg(CFG_TREE_LEVELS, ph == 4 ? 32'd7 : ph == 5 ? 32'd1 : $urandom_range(0, 4));
      for (int i = 0; i < 54; i++) begin
        if (ph == 2 && i == 20) long_hold = 1;
        op = ($urandom_range(0, 39) == 0) ? CMD_CLEAR :
             ($urandom_range(0, 49) == 0) ? CMD_UNKNOWN : 2'($urandom_range(0, 1));
        send_item(cmd_t'(op), pick_coord(tree_cx, tree_hw), pick_coord(tree_cz, tree_hh),
                  16'($urandom), ph != 3);
      end
      drain_out();
    end

    stim_done = 1;
    drain_out();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
    end
  end
endmodule

// ===== sim.f =====
sv/qgb_pkg.sv
sv/qgb_split.sv
sv/qgb_store.sv
sv/quadtree_grid_binning.sv
tb/testbench.sv
